### src/ps2q_pkg.sv
// Package for the PS/2 set 1 scan code decoder and its character queue.
// Holds the scan code constants, register indexes and the US key tables.
// No dependencies; the top level and the bench import it.
package ps2q_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int ADDR_W          = 4;

  // Configuration register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ARROW_UP    = 2'd0;
  localparam logic [1:0] REG_ARROW_DOWN  = 2'd1;
  localparam logic [1:0] REG_ARROW_LEFT  = 2'd2;
  localparam logic [1:0] REG_ARROW_RIGHT = 2'd3;

  localparam logic [7:0] ARROW_UP_RST    = 8'd128;
  localparam logic [7:0] ARROW_DOWN_RST  = 8'd129;
  localparam logic [7:0] ARROW_LEFT_RST  = 8'd130;
  localparam logic [7:0] ARROW_RIGHT_RST = 8'd131;

  // Scan codes.
  localparam logic [7:0] SC_EXTENDED    = 8'hE0;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_LCTRL_MAKE  = 8'h1D;
  localparam logic [7:0] SC_LCTRL_BRK   = 8'h9D;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_UP          = 8'h48;
  localparam logic [7:0] SC_DOWN        = 8'h50;
  localparam logic [7:0] SC_LEFT        = 8'h4B;
  localparam logic [7:0] SC_RIGHT       = 8'h4D;
  localparam logic [7:0] MAP_LEN        = 8'h3A;

  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_Z = 8'h5A;
  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_LC_Z = 8'h7A;

  // Unshifted US layout; codes without a character give zero.
  function automatic logic [7:0] lower_map(input logic [5:0] code);
    logic [7:0] c;
    unique case (code)
      6'h01: c = 8'h1B;  6'h02: c = 8'h31;  6'h03: c = 8'h32;  6'h04: c = 8'h33;
      6'h05: c = 8'h34;  6'h06: c = 8'h35;  6'h07: c = 8'h36;  6'h08: c = 8'h37;
      6'h09: c = 8'h38;  6'h0A: c = 8'h39;  6'h0B: c = 8'h30;  6'h0C: c = 8'h2D;
      6'h0D: c = 8'h3D;  6'h0E: c = 8'h08;  6'h0F: c = 8'h09;  6'h10: c = 8'h71;
      6'h11: c = 8'h77;  6'h12: c = 8'h65;  6'h13: c = 8'h72;  6'h14: c = 8'h74;
      6'h15: c = 8'h79;  6'h16: c = 8'h75;  6'h17: c = 8'h69;  6'h18: c = 8'h6F;
      6'h19: c = 8'h70;  6'h1A: c = 8'h5B;  6'h1B: c = 8'h5D;  6'h1C: c = 8'h0A;
      6'h1E: c = 8'h61;  6'h1F: c = 8'h73;  6'h20: c = 8'h64;  6'h21: c = 8'h66;
      6'h22: c = 8'h67;  6'h23: c = 8'h68;  6'h24: c = 8'h6A;  6'h25: c = 8'h6B;
      6'h26: c = 8'h6C;  6'h27: c = 8'h3B;  6'h28: c = 8'h27;  6'h29: c = 8'h60;
      6'h2B: c = 8'h5C;  6'h2C: c = 8'h7A;  6'h2D: c = 8'h78;  6'h2E: c = 8'h63;
      6'h2F: c = 8'h76;  6'h30: c = 8'h62;  6'h31: c = 8'h6E;  6'h32: c = 8'h6D;
      6'h33: c = 8'h2C;  6'h34: c = 8'h2E;  6'h35: c = 8'h2F;  6'h37: c = 8'h2A;
      6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted US layout.
  function automatic logic [7:0] upper_map(input logic [5:0] code);
    logic [7:0] c;
    unique case (code)
      6'h01: c = 8'h1B;  6'h02: c = 8'h21;  6'h03: c = 8'h40;  6'h04: c = 8'h23;
      6'h05: c = 8'h24;  6'h06: c = 8'h25;  6'h07: c = 8'h5E;  6'h08: c = 8'h26;
      6'h09: c = 8'h2A;  6'h0A: c = 8'h28;  6'h0B: c = 8'h29;  6'h0C: c = 8'h5F;
      6'h0D: c = 8'h2B;  6'h0E: c = 8'h08;  6'h0F: c = 8'h09;  6'h10: c = 8'h51;
      6'h11: c = 8'h57;  6'h12: c = 8'h45;  6'h13: c = 8'h52;  6'h14: c = 8'h54;
      6'h15: c = 8'h59;  6'h16: c = 8'h55;  6'h17: c = 8'h49;  6'h18: c = 8'h4F;
      6'h19: c = 8'h50;  6'h1A: c = 8'h7B;  6'h1B: c = 8'h7D;  6'h1C: c = 8'h0A;
      6'h1E: c = 8'h41;  6'h1F: c = 8'h53;  6'h20: c = 8'h44;  6'h21: c = 8'h46;
      6'h22: c = 8'h47;  6'h23: c = 8'h48;  6'h24: c = 8'h4A;  6'h25: c = 8'h4B;
      6'h26: c = 8'h4C;  6'h27: c = 8'h3A;  6'h28: c = 8'h22;  6'h29: c = 8'h7E;
      6'h2B: c = 8'h7C;  6'h2C: c = 8'h5A;  6'h2D: c = 8'h58;  6'h2E: c = 8'h43;
      6'h2F: c = 8'h56;  6'h30: c = 8'h42;  6'h31: c = 8'h4E;  6'h32: c = 8'h4D;
      6'h33: c = 8'h3C;  6'h34: c = 8'h3E;  6'h35: c = 8'h3F;  6'h37: c = 8'h2A;
      6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### src/ps2_scancode_to_char_queue.sv
// Top level: PS/2 scan code set 1 decoder feeding a character queue.
// Uses ps2q_pkg for scan codes, register indexes and the key tables.
// Register map: arrow up, down, left, right codes at byte addresses 0, 4, 8, 12.

// The block takes one item per clock cycle when the output side is ready: either a
// keyboard byte (s_tuser[0] low) or a read request (s_tuser[0] high) that pops one
// character if the queue holds any. Each item gives one result. An item sits in an
// input register, then a single pass of table lookup, flag update and one queue
// access (one write port, one registered read port of the character memory) fills
// the result register. The queue holds QUEUE_DEPTH characters; when it is full a
// new character is discarded and the result reports it as dropped.
// The character memory needs no clearing after reset.
module ps2_scancode_to_char_queue #(
  parameter int QUEUE_DEPTH = ps2q_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ps2q_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input items.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [7:0] data_byte
  input  logic [1:0]                  s_tuser,  // [0] kind, [1] from_aux
  // Result items.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] char_out, [8] char_valid, [9] available, [10] ctrl_active,
  // [11] dropped, [15:12] zero
  output logic [15:0]                 m_tdata
);
  import ps2q_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Configuration registers.
  logic [7:0] arrow_up, arrow_down, arrow_left, arrow_right;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrow_up    <= ARROW_UP_RST;
      arrow_down  <= ARROW_DOWN_RST;
      arrow_left  <= ARROW_LEFT_RST;
      arrow_right <= ARROW_RIGHT_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_ARROW_UP:    arrow_up    <= pwdata[7:0];
        REG_ARROW_DOWN:  arrow_down  <= pwdata[7:0];
        REG_ARROW_LEFT:  arrow_left  <= pwdata[7:0];
        REG_ARROW_RIGHT: arrow_right <= pwdata[7:0];
        default:         arrow_up    <= arrow_up;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ARROW_UP:    prdata = {24'd0, arrow_up};
      REG_ARROW_DOWN:  prdata = {24'd0, arrow_down};
      REG_ARROW_LEFT:  prdata = {24'd0, arrow_left};
      REG_ARROW_RIGHT: prdata = {24'd0, arrow_right};
      default:         prdata = 32'd0;
    endcase
  end

  // Input register.
  logic       s1_valid;
  logic       s1_kind;
  logic       s1_aux;
  logic [7:0] s1_byte;
  logic       advance;
  logic       step;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_kind <= s_tuser[0];
      s1_aux  <= s_tuser[1];
      s1_byte <= s_tdata;
    end
  end

  // Decoder state.
  logic             shift_held, shift_held_next;
  logic             ctrl_held, ctrl_held_next;
  logic             caps_on, caps_on_next;
  logic             extended_armed, extended_armed_next;
  logic [7:0]       previous_byte, previous_byte_next;
  logic [PTR_W-1:0] read_pointer, write_pointer;
  logic [CNT_W-1:0] fill_count, fill_count_next;

  logic       take;
  logic [7:0] char_new;
  logic [7:0] up_c, lo_c;
  logic       enqueue, full, wr_en, drop, pop;

  assign take = !s1_kind && !s1_aux && (s1_byte != previous_byte);
  assign up_c = upper_map(s1_byte[5:0]);
  assign lo_c = lower_map(s1_byte[5:0]);

  always_comb begin
    shift_held_next     = shift_held;
    ctrl_held_next      = ctrl_held;
    caps_on_next        = caps_on;
    extended_armed_next = extended_armed;
    previous_byte_next  = previous_byte;
    char_new            = 8'd0;
    if (take) begin
      previous_byte_next = s1_byte;
      priority if (s1_byte == SC_EXTENDED) begin
        extended_armed_next = 1'b1;
      end else if (extended_armed) begin
        // Any byte after the prefix ends it; only arrow makes produce a code.
        extended_armed_next = 1'b0;
        priority if (s1_byte == SC_UP)    char_new = arrow_up;
        else if (s1_byte == SC_DOWN)      char_new = arrow_down;
        else if (s1_byte == SC_LEFT)      char_new = arrow_left;
        else if (s1_byte == SC_RIGHT)     char_new = arrow_right;
        else                              char_new = 8'd0;
      end else if (s1_byte == SC_LSHIFT_MAKE || s1_byte == SC_RSHIFT_MAKE) begin
        shift_held_next = 1'b1;
      end else if (s1_byte == SC_LSHIFT_BRK || s1_byte == SC_RSHIFT_BRK) begin
        shift_held_next = 1'b0;
      end else if (s1_byte == SC_LCTRL_MAKE) begin
        ctrl_held_next = 1'b1;
      end else if (s1_byte == SC_LCTRL_BRK) begin
        ctrl_held_next = 1'b0;
      end else if (s1_byte == SC_CAPS) begin
        caps_on_next = !caps_on;
      end else if (s1_byte < MAP_LEN) begin
        // Caps Lock flips the case of letters only.
        if (shift_held) begin
          char_new = (caps_on && up_c >= CHAR_UC_A && up_c <= CHAR_UC_Z) ? lo_c : up_c;
        end else begin
          char_new = (caps_on && lo_c >= CHAR_LC_A && lo_c <= CHAR_LC_Z) ? up_c : lo_c;
        end
      end else begin
        char_new = 8'd0;
      end
    end
  end

  assign enqueue = take && (char_new != 8'd0);
  assign full    = (fill_count == CNT_FULL);
  assign wr_en   = enqueue && !full;
  assign drop    = enqueue && full;
  assign pop     = s1_kind && (fill_count != '0);

  always_comb begin
    fill_count_next = fill_count;
    if (wr_en) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (pop) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      ctrl_held      <= 1'b0;
      caps_on        <= 1'b0;
      extended_armed <= 1'b0;
      previous_byte  <= 8'd0;
      read_pointer   <= '0;
      write_pointer  <= '0;
      fill_count     <= '0;
    end else if (step) begin
      shift_held     <= shift_held_next;
      ctrl_held      <= ctrl_held_next;
      caps_on        <= caps_on_next;
      extended_armed <= extended_armed_next;
      previous_byte  <= previous_byte_next;
      fill_count     <= fill_count_next;
      if (wr_en) begin
        write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + PTR_W'(1);
      end
      if (pop) begin
        read_pointer <= (read_pointer == PTR_LAST) ? '0 : read_pointer + PTR_W'(1);
      end
    end
  end

  // Character memory. The read data register only loads when an item moves on,
  // so a stalled result keeps its character.
  logic [7:0] char_store [QUEUE_DEPTH];
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      char_store[write_pointer] <= char_new;
    end
    if (step) begin
      rd_data <= char_store[read_pointer];
    end
  end

  // Result register.
  logic o_valid, o_avail, o_ctrl, o_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_valid <= pop;
      o_avail <= (fill_count_next != '0);
      o_ctrl  <= ctrl_held_next;
      o_drop  <= drop;
    end
  end

  assign m_tdata = {4'd0, o_drop, o_ctrl, o_avail, o_valid, o_valid ? rd_data : 8'd0};

endmodule

### src/ps2q_checker.sv
// Port-level checker for the PS/2 decoder and character queue, bound to the top.
// Watches only the top level's ports; no package dependency.
module ps2q_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A result that is not taken holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Only nonzero characters are ever queued, so a popped one is nonzero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] != 8'd0)
    else $error("popped character is zero");

  // No pop means no character.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
    else $error("character without pop");

  // A drop only happens on a full queue, during a byte, not a read.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[9] && !m_tdata[8])
    else $error("drop with empty queue or on a read");

endmodule

bind ps2_scancode_to_char_queue ps2q_checker u_ps2q_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/ps2_scancode_to_char_queue_tb.sv
// Self-checking bench for the PS/2 set 1 scan code decoder and character queue.
// Drives scan bytes and read requests over the input stream, predicts every result
// item in the bench, and programs arrow codes over APB. Depends on ps2q_pkg.
`timescale 1ns / 100ps

module ps2_scancode_to_char_queue_tb;
  import ps2q_pkg::*;

  localparam int FIFO_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int ITEM_TARGET = 1400;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 200;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_READ = 1'b1
  } item_kind_t;

  // Same bit order as m_tdata[11:0].
  typedef struct packed {
    logic       dropped;
    logic       ctrl_active;
    logic       available;
    logic       char_valid;
    logic [7:0] char_out;
  } key_result_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  scan;
    logic        aux;
    logic        typed;
    key_result_t want;
  } dir_row_t;

  localparam key_result_t RES_NONE    = '0;
  localparam key_result_t RES_PENDING = '{dropped: 1'b0, ctrl_active: 1'b0, available: 1'b1,
                                          char_valid: 1'b0, char_out: 8'h00};
  localparam key_result_t RES_POP_UP  = '{dropped: 1'b0, ctrl_active: 1'b0, available: 1'b0,
                                          char_valid: 1'b1, char_out: ARROW_UP_RST};

  // Opening sequence from reset. Rows with typed set carry their own expectation.
  localparam dir_row_t DIRECTED [25] = '{
    '{KIND_READ, 8'h00,          1'b0, 1'b1, RES_NONE},     // read on empty queue
    '{KIND_BYTE, 8'h00,          1'b0, 1'b1, RES_NONE},     // repeats the reset previous byte
    '{KIND_BYTE, SC_EXTENDED,    1'b1, 1'b1, RES_NONE},     // mouse byte
    '{KIND_BYTE, SC_EXTENDED,    1'b0, 1'b1, RES_NONE},
    '{KIND_BYTE, SC_EXTENDED,    1'b0, 1'b1, RES_NONE},     // repeated prefix
    '{KIND_BYTE, SC_UP,          1'b0, 1'b1, RES_PENDING},
    '{KIND_BYTE, SC_DOWN,        1'b1, 1'b1, RES_PENDING},  // mouse byte keeps nothing
    '{KIND_READ, 8'hFF,          1'b1, 1'b1, RES_POP_UP},   // read ignores data and aux
    '{KIND_BYTE, 8'h1E,          1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_LSHIFT_MAKE, 1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, 8'h1E,          1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_LSHIFT_BRK,  1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_CAPS,        1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, 8'h10,          1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_RSHIFT_MAKE, 1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, 8'h10,          1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_RSHIFT_BRK,  1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_LCTRL_MAKE,  1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_LCTRL_BRK,   1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, 8'h3B,          1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, 8'hFF,          1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_EXTENDED,    1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, 8'hC8,          1'b0, 1'b0, RES_NONE},     // extended break clears prefix
    '{KIND_BYTE, SC_EXTENDED,    1'b0, 1'b0, RES_NONE},
    '{KIND_BYTE, SC_RIGHT,       1'b0, 1'b0, RES_NONE}
  };

  logic [7:0] lower_keys [58] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  logic [7:0] upper_keys [58] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [ps2q_pkg::ADDR_W-1:0] paddr    = '0;
  logic [31:0]                 pwdata   = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [7:0]                  s_tdata  = '0;  // [7:0] data_byte
  logic [1:0]                  s_tuser  = '0;  // [0] kind, [1] from_aux
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  // [7:0] char_out, [8] char_valid, [9] available, [10] ctrl_active, [11] dropped
  logic [15:0]                 m_tdata;

  // Decoder state as the bench expects it.
  logic       kb_shift     = 1'b0;
  logic       kb_ctrl      = 1'b0;
  logic       kb_caps      = 1'b0;
  logic       kb_prefix    = 1'b0;
  logic [7:0] kb_last_scan = 8'h00;
  logic [7:0] arrow_code [4] = '{ARROW_UP_RST, ARROW_DOWN_RST, ARROW_LEFT_RST, ARROW_RIGHT_RST};
  logic [7:0] char_fifo [$];

  key_result_t pending_results [$];
  int          fail_count    = 0;
  int          items_offered = 0;
  logic        sender_fast   = 1'b0;
  logic        hold_results  = 1'b0;

  ps2_scancode_to_char_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one accepted item to the bench state and returns the result it must give.
  function automatic key_result_t decode_item(item_kind_t kind, logic [7:0] scan, logic aux);
    key_result_t r;
    logic [7:0]  c;
    r = RES_NONE;
    c = 8'h00;
    if (kind == KIND_READ) begin
      if (char_fifo.size() != 0) begin
        r.char_out   = char_fifo.pop_front();
        r.char_valid = 1'b1;
      end
    end else if (!aux && scan != kb_last_scan) begin
      kb_last_scan = scan;
      if (scan == SC_EXTENDED) begin
        kb_prefix = 1'b1;
      end else if (kb_prefix) begin
        kb_prefix = 1'b0;
        case (scan)
          SC_UP:    c = arrow_code[REG_ARROW_UP];
          SC_DOWN:  c = arrow_code[REG_ARROW_DOWN];
          SC_LEFT:  c = arrow_code[REG_ARROW_LEFT];
          SC_RIGHT: c = arrow_code[REG_ARROW_RIGHT];
          default:  c = 8'h00;
        endcase
      end else if (scan == SC_LSHIFT_MAKE || scan == SC_RSHIFT_MAKE) begin
        kb_shift = 1'b1;
      end else if (scan == SC_LSHIFT_BRK || scan == SC_RSHIFT_BRK) begin
        kb_shift = 1'b0;
      end else if (scan == SC_LCTRL_MAKE) begin
        kb_ctrl = 1'b1;
      end else if (scan == SC_LCTRL_BRK) begin
        kb_ctrl = 1'b0;
      end else if (scan == SC_CAPS) begin
        kb_caps = !kb_caps;
      end else if (scan < MAP_LEN) begin
        // Caps Lock flips the case of letters only, in either shift state.
        if (kb_shift) begin
          c = upper_keys[scan];
          if (kb_caps && c >= CHAR_UC_A && c <= CHAR_UC_Z) c = lower_keys[scan];
        end else begin
          c = lower_keys[scan];
          if (kb_caps && c >= CHAR_LC_A && c <= CHAR_LC_Z) c = upper_keys[scan];
        end
      end
      if (c != 8'h00) begin
        if (char_fifo.size() >= FIFO_DEPTH) r.dropped = 1'b1;
        else char_fifo.push_back(c);
      end
    end
    r.available   = (char_fifo.size() != 0);
    r.ctrl_active = kb_ctrl;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_fast) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(1, 8'h39));
    return 8'($urandom_range(0, 8'h7F));
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // valid stays high after acceptance only when the next item follows at once.
  task automatic send_item(item_kind_t kind, logic [7:0] scan, logic aux,
                           logic typed = 1'b0, key_result_t want = RES_NONE);
    key_result_t r;
    int          gap;
    s_tvalid <= 1'b1;
    s_tdata  <= scan;
    s_tuser  <= {aux, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = decode_item(kind, scan, aux);
    pending_results.push_back(typed ? want : r);
    if (!(kind == KIND_BYTE && aux)) items_offered++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_scan(logic [7:0] scan);
    send_item(KIND_BYTE, scan, 1'b0);
  endtask

  task automatic send_read();
    send_item(KIND_READ, 8'($urandom), 1'($urandom));
  endtask

  // Make, sometimes a typematic repeat of it, then break.
  task automatic press_key(logic [7:0] make);
    send_scan(make);
    if ($urandom_range(0, 9) == 0) send_scan(make);
    send_scan(make | 8'h80);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_cycle(logic write, logic [1:0] idx, logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] code);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, {24'h0, code}, rd);
    arrow_code[idx] = code;
    apb_cycle(1'b0, idx, 32'h0, rd);
    if (rd[7:0] !== code) begin
      $error("arrow register %0d: expected 0x%0h, got 0x%0h", idx, code, rd[7:0]);
      fail_count++;
    end
  endtask

  task automatic apply_setting(int phase);
    logic [7:0] codes [4];
    case (phase)
      0:       codes = '{8'd1, 8'd255, 8'd1, 8'd255};
      1:       codes = '{8'd255, 8'd1, 8'd255, 8'd1};
      // A zero code means that arrow queues nothing.
      2:       codes = '{8'd0, 8'd128, 8'd200, 8'd7};
      default: foreach (codes[i]) codes[i] = 8'($urandom_range(1, 255));
    endcase
    write_reg(REG_ARROW_UP,    codes[REG_ARROW_UP]);
    write_reg(REG_ARROW_DOWN,  codes[REG_ARROW_DOWN]);
    write_reg(REG_ARROW_LEFT,  codes[REG_ARROW_LEFT]);
    write_reg(REG_ARROW_RIGHT, codes[REG_ARROW_RIGHT]);
  endtask

  task automatic run_random_sequence();
    int         r;
    int         n;
    logic [7:0] k;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      press_key(pick_key());
    end else if (r < 35) begin
      k = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
      send_scan(k);
      press_key(pick_key());
      send_scan(k == SC_LSHIFT_MAKE ? SC_LSHIFT_BRK : SC_RSHIFT_BRK);
    end else if (r < 50) begin
      repeat ($urandom_range(1, 3)) send_read();
    end else if (r < 60) begin
      case ($urandom_range(0, 4))
        0:       k = SC_UP;
        1:       k = SC_DOWN;
        2:       k = SC_LEFT;
        3:       k = SC_RIGHT;
        default: k = 8'($urandom);
      endcase
      send_scan(SC_EXTENDED);
      send_scan(k);
      if ($urandom_range(0, 2) == 0) begin
        send_scan(SC_EXTENDED);
        send_scan(k | 8'h80);
      end
    end else if (r < 66) begin
      send_scan(SC_CAPS);
      send_scan(SC_CAPS | 8'h80);
    end else if (r < 72) begin
      send_scan(SC_LCTRL_MAKE);
      press_key(pick_key());
      send_scan(SC_LCTRL_BRK);
    end else if (r < 84) begin
      send_item(item_kind_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom));
    end else begin
      n = $urandom_range(2, 5);
      repeat (n) press_key(pick_key());
      repeat (n) send_read();
    end
  endtask

  // Types until the queue is full and past it, then reads it empty and beyond.
  task automatic overflow_queue();
    logic [7:0] k;
    int         extra;
    extra = 0;
    while (char_fifo.size() < FIFO_DEPTH || extra < 6) begin
      if (char_fifo.size() >= FIFO_DEPTH) extra++;
      do k = 8'($urandom_range(1, 8'h39)); while (lower_keys[k] == 8'h00);
      press_key(k);
    end
    while (char_fifo.size() != 0) send_read();
    repeat (3) send_read();
  endtask

  always @(posedge clk) begin : result_check
    key_result_t got;
    key_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = key_result_t'(m_tdata[11:0]);
      if (pending_results.size() == 0) begin
        $error("result 0x%0h arrived with nothing expected", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("char_out", want.char_out, got.char_out);
        check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
        check_field("available", 8'(want.available), 8'(got.available));
        check_field("ctrl_active", 8'(want.ctrl_active), 8'(got.ctrl_active));
        check_field("dropped", 8'(want.dropped), 8'(got.dropped));
      end
    end
  end

  // Result side: mostly ready, with short and occasional long stalls, plus one long
  // hold-off on request so that the block backs up into its input.
  initial begin : result_sink
    int r;
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else if (r < 80) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(2, 24)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          if (r < 97) repeat ($urandom_range(1, 3)) @(posedge clk);
          else repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].kind, DIRECTED[i].scan, DIRECTED[i].aux,
                DIRECTED[i].typed, DIRECTED[i].want);
    phase = 0;
    while (items_offered < ITEM_TARGET) begin
      wait_drained();
      apply_setting(phase);
      if (phase == 2) begin
        hold_results = 1'b1;
        sender_fast  = 1'b1;
        repeat (12) run_random_sequence();
        sender_fast  = 1'b0;
      end
      if (phase == 3) overflow_queue();
      phase_end = items_offered + PHASE_ITEMS;
      while (items_offered < phase_end && items_offered < ITEM_TARGET) begin
        if ($urandom_range(0, 15) == 0) sender_fast = !sender_fast;
        run_random_sequence();
      end
      sender_fast = 1'b0;
      phase++;
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
src/ps2q_pkg.sv
src/ps2_scancode_to_char_queue.sv
src/ps2q_checker.sv
bench/ps2_scancode_to_char_queue_tb.sv
